[design/owm_pkg.sv]
// Shared types, constants and helpers for the 1-Wire bus master.
package owm_pkg;

    localparam int TIME_WIDTH = 10;
    // Duration compare width: holds any register value and 2^TIME_WIDTH
    localparam int DUR_W = ((TIME_WIDTH > 10) ? TIME_WIDTH : 10) + 1;
    localparam logic [DUR_W-1:0] DUR_LIM = DUR_W'(2 ** TIME_WIDTH);

    localparam int OP_W = 3;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 10;

    // Command codes
    localparam logic [OP_W-1:0] OP_NONE     = 3'd0;
    localparam logic [OP_W-1:0] OP_RESET    = 3'd1;
    localparam logic [OP_W-1:0] OP_WR_BIT   = 3'd2;
    localparam logic [OP_W-1:0] OP_RD_BIT   = 3'd3;
    localparam logic [OP_W-1:0] OP_WR_BYTE  = 3'd4;
    localparam logic [OP_W-1:0] OP_RD_BYTE  = 3'd5;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_RESET_LOW    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PRESENCE_WAIT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RESET_RECOVER = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SHORT_LOW    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_LOW     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_READ_SAMPLE  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SLOT_LEN     = 3'd6;

    // Phase codes
    localparam logic [2:0] PH_IDLE     = 3'd0;
    localparam logic [2:0] PH_RST_LOW  = 3'd1;
    localparam logic [2:0] PH_RST_WAIT = 3'd2;
    localparam logic [2:0] PH_RST_REC  = 3'd3;
    localparam logic [2:0] PH_SLOT     = 3'd4;

    typedef struct packed {
        logic [9:0] reset_low_us;
        logic [9:0] presence_wait_us;
        logic [9:0] reset_recover_us;
        logic [6:0] short_low_us;
        logic [6:0] long_low_us;
        logic [6:0] read_sample_us;
        logic [6:0] slot_len_us;
    } cfg_t;

    typedef struct packed {
        logic       drive_low;
        logic       busy_res;
        logic       done_res;
        logic       presence;
        logic [7:0] read_data;
        logic       rejected;
    } result_t;

    // Zero acts as one, anything past 2^TIME_WIDTH is clamped
    function automatic logic [DUR_W-1:0] eff_dur(input logic [9:0] v);
        logic [DUR_W-1:0] d;
        d = DUR_W'(v);
        if (v == 10'd0) begin
            d = DUR_W'(1);
        end
        if (d > DUR_LIM) begin
            d = DUR_LIM;
        end
        return d;
    endfunction

    function automatic logic [TIME_WIDTH-1:0] ext7(input logic [6:0] v);
        return {{(TIME_WIDTH-7){1'b0}}, v};
    endfunction

endpackage

[design/onewire_bus_master.sv]
// 1-Wire bus master timing engine, top level.
//
//  channel | ports          | transaction
//  --------+----------------+-------------------------------------------
//  s_      | s_valid/s_ready| one microsecond tick: op, wr_data, line_in
//  m_      | m_valid/m_ready| one result per tick: drive_low, status, data
//  cfg_    | cfg_wr_en      | timing register write, no wait
//
// One tick per clock while s_ready is high; the result appears in the cycle after the tick is taken.
// A bus reset spans reset_low + presence_wait + reset_recover ticks; a bit
// slot spans slot_len ticks, a byte eight slots.
// Reset clears the sequencer and restores the default timing registers.
// s_ready drops only while the result register is full and m_ready is low.
module onewire_bus_master
    import owm_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [OP_W-1:0]       s_op,
    input  logic [7:0]            s_wr_data,
    input  logic                  s_line_in,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_drive_low,
    output logic                  m_busy_res,
    output logic                  m_done_res,
    output logic                  m_presence,
    output logic [7:0]            m_read_data,
    output logic                  m_rejected
);

    cfg_t    cfg;
    result_t res_comb, res_q;
    logic    accept;

    assign accept = s_valid && s_ready;

    owm_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    owm_engine u_engine (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (accept),
        .op      (s_op),
        .wr_data (s_wr_data),
        .line_in (s_line_in),
        .cfg     (cfg),
        .res     (res_comb)
    );

    owm_out_reg u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (accept),
        .res_in   (res_comb),
        .m_ready  (m_ready),
        .m_valid  (m_valid),
        .can_load (s_ready),
        .res_out  (res_q)
    );

    assign m_drive_low = res_q.drive_low;
    assign m_busy_res  = res_q.busy_res;
    assign m_done_res  = res_q.done_res;
    assign m_presence  = res_q.presence;
    assign m_read_data = res_q.read_data;
    assign m_rejected  = res_q.rejected;

    a_done_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_done_res |-> m_busy_res)
        else $error("done without busy");

    a_reject_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_rejected |-> m_busy_res)
        else $error("rejection while idle");

    a_rdata_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_read_data != 8'd0) |-> m_done_res)
        else $error("read data outside done tick");

    a_stall_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("input stalled with room in result register");

endmodule

[design/owm_cfg_regs.sv]
// Timing register file of the 1-Wire bus master.
module owm_cfg_regs
    import owm_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.reset_low_us     <= 10'd480;
            cfg_reg.presence_wait_us <= 10'd70;
            cfg_reg.reset_recover_us <= 10'd410;
            cfg_reg.short_low_us     <= 7'd6;
            cfg_reg.long_low_us      <= 7'd60;
            cfg_reg.read_sample_us   <= 7'd15;
            cfg_reg.slot_len_us      <= 7'd70;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_RESET_LOW:     cfg_reg.reset_low_us     <= cfg_wdata;
                REG_PRESENCE_WAIT: cfg_reg.presence_wait_us <= cfg_wdata;
                REG_RESET_RECOVER: cfg_reg.reset_recover_us <= cfg_wdata;
                REG_SHORT_LOW:     cfg_reg.short_low_us     <= cfg_wdata[6:0];
                REG_LONG_LOW:      cfg_reg.long_low_us      <= cfg_wdata[6:0];
                REG_READ_SAMPLE:   cfg_reg.read_sample_us   <= cfg_wdata[6:0];
                REG_SLOT_LEN:      cfg_reg.slot_len_us      <= cfg_wdata[6:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

[design/owm_engine.sv]
// Phase sequencer: advances one microsecond tick per accepted transaction.
module owm_engine
    import owm_pkg::*;
(
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            step,
    input  logic [OP_W-1:0] op,
    input  logic [7:0]      wr_data,
    input  logic            line_in,
    input  cfg_t            cfg,
    output result_t         res
);

    logic [2:0]            phase_reg, phase_next;
    logic [TIME_WIDTH-1:0] ticks_reg, ticks_next;
    logic [3:0]            bit_reg, bit_next;
    logic [7:0]            shift_reg, shift_next;
    logic                  presence_reg, presence_next;
    logic [OP_W-1:0]       op_reg, op_next;

    logic                  cmd, start, rd, byte_op, slot_end;
    logic [2:0]            cur_phase, bi;
    logic [TIME_WIDTH-1:0] cur_ticks;
    logic [3:0]            cur_bit;
    logic [7:0]            cur_shift, init_shift;
    logic [OP_W-1:0]       cur_op;
    logic [DUR_W-1:0]      t1;
    logic [6:0]            pulse_len;

    always_comb begin
        cmd = (op >= OP_RESET) && (op <= OP_RD_BYTE);
        start = (phase_reg == PH_IDLE) && cmd;

        case (op)
            OP_WR_BIT:  init_shift = {7'd0, wr_data[0]};
            OP_WR_BYTE: init_shift = wr_data;
            default:    init_shift = 8'd0;
        endcase

        // The accepting tick is already the command's first tick
        cur_phase = start ? ((op == OP_RESET) ? PH_RST_LOW : PH_SLOT) : phase_reg;
        cur_ticks = start ? '0 : ticks_reg;
        cur_bit   = start ? 4'd0 : bit_reg;
        cur_shift = start ? init_shift : shift_reg;
        cur_op    = start ? op : op_reg;

        phase_next    = cur_phase;
        ticks_next    = cur_ticks;
        bit_next      = cur_bit;
        shift_next    = cur_shift;
        presence_next = presence_reg;
        op_next       = cur_op;

        t1 = DUR_W'(cur_ticks) + DUR_W'(1);
        rd = (cur_op == OP_RD_BIT) || (cur_op == OP_RD_BYTE);
        byte_op = (cur_op == OP_WR_BYTE) || (cur_op == OP_RD_BYTE);
        bi = cur_bit[2:0];
        pulse_len = (rd || cur_shift[bi]) ? cfg.short_low_us : cfg.long_low_us;
        slot_end = 1'b0;

        res.drive_low = 1'b0;
        res.busy_res  = (cur_phase != PH_IDLE);
        res.done_res  = 1'b0;
        res.read_data = 8'd0;
        res.rejected  = (phase_reg != PH_IDLE) && cmd;

        unique case (cur_phase)
            PH_RST_LOW: begin
                res.drive_low = 1'b1;
                if (t1 >= eff_dur(cfg.reset_low_us)) begin
                    phase_next = PH_RST_WAIT;
                    ticks_next = '0;
                end else begin
                    ticks_next = t1[TIME_WIDTH-1:0];
                end
            end
            PH_RST_WAIT: begin
                if (t1 >= eff_dur(cfg.presence_wait_us)) begin
                    phase_next = PH_RST_REC;
                    ticks_next = '0;
                end else begin
                    ticks_next = t1[TIME_WIDTH-1:0];
                end
            end
            PH_RST_REC: begin
                // presence: a device holds the line low on the first recovery tick
                if (cur_ticks == '0) begin
                    presence_next = ~line_in;
                end
                if (t1 >= eff_dur(cfg.reset_recover_us)) begin
                    phase_next = PH_IDLE;
                    ticks_next = '0;
                    res.done_res = 1'b1;
                end else begin
                    ticks_next = t1[TIME_WIDTH-1:0];
                end
            end
            PH_SLOT: begin
                res.drive_low = (cur_ticks < ext7(pulse_len));
                if (rd && (cur_ticks == ext7(cfg.read_sample_us))) begin
                    shift_next[bi] = line_in;
                end
                slot_end = (t1 >= eff_dur({3'd0, cfg.slot_len_us}));
                if (slot_end) begin
                    ticks_next = '0;
                    bit_next = cur_bit + 4'd1;
                    if (bit_next >= (byte_op ? 4'd8 : 4'd1)) begin
                        phase_next = PH_IDLE;
                        res.done_res = 1'b1;
                        if (rd) begin
                            res.read_data = shift_next;
                        end
                    end
                end else begin
                    ticks_next = t1[TIME_WIDTH-1:0];
                end
            end
            default: ;
        endcase

        res.presence = presence_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_IDLE;
            ticks_reg    <= '0;
            bit_reg      <= 4'd0;
            shift_reg    <= 8'd0;
            presence_reg <= 1'b0;
            op_reg       <= OP_NONE;
        end else if (step) begin
            phase_reg    <= phase_next;
            ticks_reg    <= ticks_next;
            bit_reg      <= bit_next;
            shift_reg    <= shift_next;
            presence_reg <= presence_next;
            op_reg       <= op_next;
        end
    end

endmodule

[design/owm_out_reg.sv]
// Result register between the sequencer and the result channel.
module owm_out_reg
    import owm_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    load,
    input  result_t res_in,
    input  logic    m_ready,
    output logic    m_valid,
    output logic    can_load,
    output result_t res_out
);

    logic    valid_reg;
    result_t data_reg;

    assign can_load = !valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= res_in;
        end
    end

    assign m_valid = valid_reg;
    assign res_out = data_reg;

endmodule
